### hw/rtl/thread_ready_queue_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Thread ready-queue scheduler: assertion macros
// Concurrent assertion helpers, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THREAD_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define THREAD_READY_QUEUE_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define TRQS_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("trqs: same-cycle check failed");

// next-cycle implication
`define TRQS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("trqs: next-cycle check failed");

`endif

### hw/rtl/trqs_pkg.sv
// ----------------------------------------------------------------------------
// trqs_pkg
// Shared types and codes of the thread ready-queue scheduler.
// ----------------------------------------------------------------------------
package trqs_pkg;

   // width of the id fields on the ports
   localparam int ID_W = 6;

   typedef enum logic [1:0] {
      OP_CREATE  = 2'd0,
      OP_YIELD   = 2'd1,
      OP_DESTROY = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_NAMED = 2'd0,
      KIND_SELF  = 2'd1,
      KIND_ANY   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NONE    = 2'd1,
      ST_INVALID = 2'd2,
      ST_NOROOM  = 2'd3
   } status_type;

   // source of the result id
   typedef enum logic [1:0] {
      ID_NONE  = 2'd0,
      ID_CUR   = 2'd1,
      ID_TAKEN = 2'd2,
      ID_CAND  = 2'd3
   } id_sel_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_FREE_SCAN,
      S_CREATE_FIN,
      S_Q_SCAN,
      S_Q_EVAL,
      S_APPEND,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      PATH_RESULT,
      PATH_FREE,
      PATH_QUEUE
   } path_type;

   typedef struct packed {
      logic       capture;
      logic       scan_init;
      logic       clear_step;
      logic       free_step;
      logic       queue_step;
      logic       count_dec;
      logic       unmark;
      logic       append_cur;
      logic       append_cand;
      logic       cur_take;
      logic       set_res;
      status_type res_status;
      id_sel_type res_sel;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      op_type   op;
      kind_type kind;
      logic     empty;
      logic     full;
      logic     tid_is_cur;
      logic     clr_done;
      logic     free_hit;
      logic     free_last;
      logic     q_last;
      logic     found;
      logic     out_free;
   } sts_type;

endpackage

### hw/rtl/trqs_ctrl.sv
// ----------------------------------------------------------------------------
// trqs_ctrl
// Sequencer of the scheduler: decodes a request and steps the datapath.
// ----------------------------------------------------------------------------
module trqs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  trqs_pkg::sts_type sts,
   output trqs_pkg::cmd_type cmd
);

   trqs_pkg::state_type  state_ff;
   trqs_pkg::state_type  state_in;
   trqs_pkg::path_type   disp_path;
   trqs_pkg::status_type disp_status;
   trqs_pkg::id_sel_type disp_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trqs_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // request decode, used by both next-state and output logic
   always_comb begin
      disp_path   = trqs_pkg::PATH_RESULT;
      disp_status = trqs_pkg::ST_INVALID;
      disp_sel    = trqs_pkg::ID_NONE;
      case (sts.op)
         trqs_pkg::OP_CREATE: begin
            if (sts.full) begin
               disp_status = trqs_pkg::ST_NOROOM;
            end else begin
               disp_path = trqs_pkg::PATH_FREE;
            end
         end
         trqs_pkg::OP_YIELD: begin
            case (sts.kind)
               trqs_pkg::KIND_SELF: begin
                  if (sts.empty) begin
                     disp_status = trqs_pkg::ST_NONE;
                  end else begin
                     disp_status = trqs_pkg::ST_OK;
                     disp_sel    = trqs_pkg::ID_CUR;
                  end
               end
               trqs_pkg::KIND_ANY: begin
                  if (sts.empty) begin
                     disp_status = trqs_pkg::ST_NONE;
                  end else begin
                     disp_path = trqs_pkg::PATH_QUEUE;
                  end
               end
               trqs_pkg::KIND_NAMED: begin
                  if (sts.tid_is_cur) begin
                     disp_status = trqs_pkg::ST_OK;
                     disp_sel    = trqs_pkg::ID_CUR;
                  end else if (!sts.empty) begin
                     disp_path = trqs_pkg::PATH_QUEUE;
                  end
               end
               default: ;
            endcase
         end
         trqs_pkg::OP_DESTROY: begin
            case (sts.kind)
               trqs_pkg::KIND_SELF, trqs_pkg::KIND_ANY: begin
                  if (sts.empty) begin
                     disp_status = trqs_pkg::ST_NONE;
                  end else begin
                     disp_path = trqs_pkg::PATH_QUEUE;
                  end
               end
               trqs_pkg::KIND_NAMED: begin
                  // the running id is never queued, so it falls out as invalid
                  if (!sts.empty) begin
                     disp_path = trqs_pkg::PATH_QUEUE;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         trqs_pkg::S_CLEAR: begin
            if (sts.clr_done) begin
               state_in = trqs_pkg::S_IDLE;
            end
         end
         trqs_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = trqs_pkg::S_DISPATCH;
            end
         end
         trqs_pkg::S_DISPATCH: begin
            case (disp_path)
               trqs_pkg::PATH_FREE:  state_in = trqs_pkg::S_FREE_SCAN;
               trqs_pkg::PATH_QUEUE: state_in = trqs_pkg::S_Q_SCAN;
               default:              state_in = trqs_pkg::S_DONE;
            endcase
         end
         trqs_pkg::S_FREE_SCAN: begin
            if (sts.free_hit) begin
               state_in = trqs_pkg::S_CREATE_FIN;
            end else if (sts.free_last) begin
               state_in = trqs_pkg::S_DONE;
            end
         end
         trqs_pkg::S_CREATE_FIN: state_in = trqs_pkg::S_DONE;
         trqs_pkg::S_Q_SCAN: begin
            if (sts.q_last) begin
               state_in = trqs_pkg::S_Q_EVAL;
            end
         end
         trqs_pkg::S_Q_EVAL: begin
            if (sts.found && (sts.op == trqs_pkg::OP_YIELD)) begin
               state_in = trqs_pkg::S_APPEND;
            end else begin
               state_in = trqs_pkg::S_DONE;
            end
         end
         trqs_pkg::S_APPEND: state_in = trqs_pkg::S_DONE;
         trqs_pkg::S_DONE: begin
            if (sts.out_free) begin
               state_in = trqs_pkg::S_IDLE;
            end
         end
         default: state_in = trqs_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.res_status = trqs_pkg::ST_INVALID;
      cmd.res_sel    = trqs_pkg::ID_NONE;
      req_stall      = (state_ff != trqs_pkg::S_IDLE);
      case (state_ff)
         trqs_pkg::S_CLEAR: cmd.clear_step = 1'b1;
         trqs_pkg::S_IDLE:  cmd.capture    = req_valid;
         trqs_pkg::S_DISPATCH: begin
            if (disp_path == trqs_pkg::PATH_RESULT) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = disp_status;
               cmd.res_sel    = disp_sel;
            end else begin
               cmd.scan_init = 1'b1;
            end
         end
         trqs_pkg::S_FREE_SCAN: begin
            cmd.free_step = 1'b1;
            if (!sts.free_hit && sts.free_last) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = trqs_pkg::ST_NOROOM;
            end
         end
         trqs_pkg::S_CREATE_FIN: begin
            cmd.append_cand = 1'b1;
            cmd.set_res     = 1'b1;
            cmd.res_status  = trqs_pkg::ST_OK;
            cmd.res_sel     = trqs_pkg::ID_CAND;
         end
         trqs_pkg::S_Q_SCAN: cmd.queue_step = 1'b1;
         trqs_pkg::S_Q_EVAL: begin
            if (!sts.found) begin
               cmd.set_res = 1'b1;
            end else begin
               cmd.count_dec = 1'b1;
               cmd.unmark    = 1'b1;
               if (sts.op != trqs_pkg::OP_YIELD) begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = trqs_pkg::ST_OK;
                  if (sts.kind == trqs_pkg::KIND_SELF) begin
                     cmd.cur_take = 1'b1;
                     cmd.res_sel  = trqs_pkg::ID_CUR;
                  end else begin
                     cmd.res_sel  = trqs_pkg::ID_TAKEN;
                  end
               end
            end
         end
         trqs_pkg::S_APPEND: begin
            cmd.append_cur = 1'b1;
            cmd.cur_take   = 1'b1;
            cmd.set_res    = 1'b1;
            cmd.res_status = trqs_pkg::ST_OK;
            cmd.res_sel    = trqs_pkg::ID_TAKEN;
         end
         trqs_pkg::S_DONE: cmd.load_rsp = sts.out_free;
         default: ;
      endcase
   end

endmodule

### hw/rtl/trqs_datapath.sv
// ----------------------------------------------------------------------------
// trqs_datapath
// Ready queue memory, queued-id bitmap, scan engines and result register.
// ----------------------------------------------------------------------------
module trqs_datapath #(
   parameter int MAX_THREADS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [1:0]                  req_operation,
   input  logic [1:0]                  req_target_kind,
   input  logic [trqs_pkg::ID_W-1:0]   req_target_id,
   input  trqs_pkg::cmd_type           cmd,
   output trqs_pkg::sts_type           sts,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [trqs_pkg::ID_W-1:0]   rsp_result_id,
   output logic [trqs_pkg::ID_W-1:0]   rsp_running_id
);

   localparam int QW = $clog2(MAX_THREADS);
   localparam int CW = $clog2(MAX_THREADS + 1);
   localparam int IW = (QW > trqs_pkg::ID_W) ? QW : trqs_pkg::ID_W;
   localparam logic [CW-1:0] MaxCnt  = CW'(MAX_THREADS);
   localparam logic [CW-1:0] LastCnt = CW'(MAX_THREADS - 1);
   localparam logic [QW-1:0] LastId  = QW'(MAX_THREADS - 1);

   // request
   trqs_pkg::op_type          op_ff;
   trqs_pkg::kind_type        kind_ff;
   logic [trqs_pkg::ID_W-1:0] tid_ff;

   // scheduler state
   logic [QW-1:0] cur_ff;
   logic [CW-1:0] cnt_ff;
   logic [QW-1:0] q_mem [MAX_THREADS];
   logic          bmp_mem [MAX_THREADS];   // 1: id is queued

   // scan engines
   logic [QW-1:0] q_rd_ff;
   logic          bmp_rd_ff;
   logic [CW-1:0] sweep_ff;
   logic [QW-1:0] chk_c_ff;
   logic          chk_cvld_ff;
   logic [CW-1:0] rd_i_ff;
   logic [QW-1:0] chk_j_ff;
   logic          chk_vld_ff;
   logic          found_ff;
   logic [QW-1:0] taken_ff;
   logic [QW-1:0] cand_ff;

   // result
   trqs_pkg::status_type      res_status_ff;
   logic [IW-1:0]             res_id_ff;
   logic [IW-1:0]             res_id_in;
   trqs_pkg::status_type      rsp_status_ff;
   logic [trqs_pkg::ID_W-1:0] rsp_result_id_ff;
   logic [trqs_pkg::ID_W-1:0] rsp_running_id_ff;
   logic                      rsp_valid_ff;

   logic          free_issue;
   logic          free_hit;
   logic          q_issue;
   logic          q_match;
   logic          q_take;
   logic          q_shift;
   logic [IW-1:0] cur_ext;
   logic          q_we;
   logic [QW-1:0] q_wa;
   logic [QW-1:0] q_wd;
   logic          b_we;
   logic [QW-1:0] b_wa;
   logic          b_wd;

   assign cur_ext    = IW'(cur_ff);
   assign free_issue = cmd.free_step && (sweep_ff < MaxCnt);
   assign free_hit   = chk_cvld_ff && !bmp_rd_ff && (chk_c_ff != cur_ff);
   assign q_issue    = cmd.queue_step && (rd_i_ff < cnt_ff);
   assign q_match    = (kind_ff == trqs_pkg::KIND_NAMED) ?
                       (IW'(q_rd_ff) == IW'(tid_ff)) : (chk_j_ff == '0);
   assign q_take     = chk_vld_ff && !found_ff && q_match;
   assign q_shift    = chk_vld_ff && found_ff;

   // queue write port: shift down behind the removed entry, or append at tail
   always_comb begin
      q_we = 1'b0;
      q_wa = '0;
      q_wd = '0;
      if (q_shift) begin
         q_we = 1'b1;
         q_wa = chk_j_ff - QW'(1);
         q_wd = q_rd_ff;
      end else if (cmd.append_cur) begin
         q_we = 1'b1;
         q_wa = cnt_ff[QW-1:0];
         q_wd = cur_ff;
      end else if (cmd.append_cand) begin
         q_we = 1'b1;
         q_wa = cnt_ff[QW-1:0];
         q_wd = cand_ff;
      end
   end

   // bitmap write port
   always_comb begin
      b_we = 1'b0;
      b_wa = '0;
      b_wd = 1'b0;
      if (cmd.clear_step) begin
         b_we = 1'b1;
         b_wa = sweep_ff[QW-1:0];
      end else if (cmd.unmark) begin
         b_we = 1'b1;
         b_wa = taken_ff;
      end else if (cmd.append_cur) begin
         b_we = 1'b1;
         b_wa = cur_ff;
         b_wd = 1'b1;
      end else if (cmd.append_cand) begin
         b_we = 1'b1;
         b_wa = cand_ff;
         b_wd = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[q_wa] <= q_wd;
      end
      if (q_issue) begin
         q_rd_ff <= q_mem[rd_i_ff[QW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bmp_mem[b_wa] <= b_wd;
      end
      if (free_issue) begin
         bmp_rd_ff <= bmp_mem[sweep_ff[QW-1:0]];
      end
   end

   always_comb begin
      case (cmd.res_sel)
         trqs_pkg::ID_CUR:   res_id_in = cur_ext;
         trqs_pkg::ID_TAKEN: res_id_in = IW'(taken_ff);
         trqs_pkg::ID_CAND:  res_id_in = IW'(cand_ff);
         default:            res_id_in = '0;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         cur_ff       <= '0;
         sweep_ff     <= '0;
         rd_i_ff      <= '0;
         chk_cvld_ff  <= 1'b0;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.scan_init) begin
            sweep_ff <= CW'(1);
            rd_i_ff  <= '0;
            found_ff <= 1'b0;
         end else begin
            if (cmd.clear_step || free_issue) begin
               sweep_ff <= sweep_ff + CW'(1);
            end
            if (q_issue) begin
               rd_i_ff <= rd_i_ff + CW'(1);
            end
            if (q_take) begin
               found_ff <= 1'b1;
            end
         end
         chk_cvld_ff <= free_issue;
         chk_vld_ff  <= q_issue;
         if (cmd.count_dec) begin
            cnt_ff <= cnt_ff - CW'(1);
         end else if (cmd.append_cur || cmd.append_cand) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
         if (cmd.cur_take) begin
            cur_ff <= taken_ff;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= trqs_pkg::op_type'(req_operation);
         kind_ff <= trqs_pkg::kind_type'(req_target_kind);
         tid_ff  <= req_target_id;
      end
      if (free_issue) begin
         chk_c_ff <= sweep_ff[QW-1:0];
      end
      if (cmd.free_step && free_hit) begin
         cand_ff <= chk_c_ff;
      end
      if (q_issue) begin
         chk_j_ff <= rd_i_ff[QW-1:0];
      end
      if (q_take) begin
         taken_ff <= q_rd_ff;
      end
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_status;
         res_id_ff     <= res_id_in;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff     <= res_status_ff;
         rsp_result_id_ff  <= res_id_ff[trqs_pkg::ID_W-1:0];
         rsp_running_id_ff <= cur_ext[trqs_pkg::ID_W-1:0];
      end
   end

   always_comb begin
      sts.op         = op_ff;
      sts.kind       = kind_ff;
      sts.empty      = (cnt_ff == '0);
      sts.full       = (cnt_ff >= LastCnt);
      sts.tid_is_cur = (IW'(tid_ff) == cur_ext);
      sts.clr_done   = (sweep_ff == LastCnt);
      sts.free_hit   = free_hit;
      sts.free_last  = chk_cvld_ff && (chk_c_ff == LastId);
      sts.q_last     = chk_vld_ff && (CW'(chk_j_ff) == (cnt_ff - CW'(1)));
      sts.found      = found_ff;
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_result_id  = rsp_result_id_ff;
   assign rsp_running_id = rsp_running_id_ff;

endmodule

### hw/rtl/thread_ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// thread_ready_queue_scheduler
// Bookkeeping scheduler: running thread id plus an ordered ready queue.
//
// One request item is taken at a time (req_stall is low only while idle) and
// gives exactly one response item. After reset the block clears its queued-id
// bitmap before it takes the first item. Outcomes settled at decode (unused
// codes, full queue, empty queue, yield to self or to the running id by name)
// go straight to the response. Create walks the bitmap one candidate id per
// cycle from id 1 and stops at the first id that is neither queued nor
// running. Yield and destroy walk the queue memory one entry per cycle
// through its single read port, shifting later entries down behind the
// removed one. The whole queue is walked whether or not the id is found, and
// a yield that finds its id then appends the old running id at the tail. The
// response sits in an output register, so a stall on rsp_ holds only that
// item; a new item is taken meanwhile and waits at its end until the register
// is free.
// ----------------------------------------------------------------------------
`include "thread_ready_queue_scheduler_assert.svh"

module thread_ready_queue_scheduler #(
   parameter int MAX_THREADS = 64
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [1:0] req_target_kind,
   input  logic [5:0] req_target_id,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [5:0] rsp_result_id,
   output logic [5:0] rsp_running_id
);

   trqs_pkg::cmd_type cmd;   // sequencer -> datapath
   trqs_pkg::sts_type sts;   // datapath -> sequencer

   // sequencer: decode, scan control, result hand-off
   trqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // queue memory, bitmap, running id and the response register
   trqs_datapath #(
      .MAX_THREADS (MAX_THREADS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_operation   (req_operation),
      .req_target_kind (req_target_kind),
      .req_target_id   (req_target_id),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_result_id   (rsp_result_id),
      .rsp_running_id  (rsp_running_id)
   );

   // an accepted item always keeps the block busy for the next cycle
   `TRQS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   // failed requests report id zero
   `TRQS_ASSERT_IMPL(a_err_id_zero, rsp_valid && (rsp_status != trqs_pkg::ST_OK), rsp_result_id == '0)
   // a response only appears out of a busy cycle
   `TRQS_ASSERT_IMPL(a_rsp_after_busy, $rose(rsp_valid), $past(req_stall))

endmodule
